@@ rtl/smpe_pkg.sv @@
`timescale 1ns / 1ps

package smpe_pkg;

  // Button slots kept by default; the packet always reports buttons 0 and 1.
  localparam int BtnCountDef = 3;

  // Most results one event can cause (the three-byte packet).
  localparam int ResMax    = 3;
  localparam int ResCntW   = $clog2(ResMax + 1);

  // Result queue depth; must hold one full packet.
  localparam int TxqDepth  = 4;

  localparam logic [7:0] IdByte     = 8'h4D;
  localparam logic [1:0] SyncBits   = 2'b01;  // top bits of the first packet byte
  localparam logic [1:0] DataBits   = 2'b00;  // top bits of the data bytes

  typedef enum logic [2:0] {
    CMD_MOTION = 3'd0,
    CMD_BUTTON = 3'd1,
    CMD_DTR    = 3'd2,
    CMD_RTS    = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       byte_valid;
    logic       clear_to_send;
    logic       last_of_run;
  } res_t;

  // Results of one event, handed from the core to the result queue.
  typedef struct packed {
    logic [ResCntW-1:0]    cnt;
    res_t [ResMax-1:0]     res;
  } push_t;

  function automatic logic signed [15:0] sat16(logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp8(logic signed [15:0] v);
    logic [7:0] r;
    if (v > 16'sd127) begin
      r = 8'h7F;
    end else if (v < -16'sd128) begin
      r = 8'h80;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/smpe_if.sv @@
`timescale 1ns / 1ps

// Event channel into the engine.
interface smpe_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [11:0] move_x;
  logic signed [11:0] move_y;
  logic [2:0]         button_index;
  logic               button_down;
  logic               line_level;

  modport source (
    output valid, command, move_x, move_y, button_index, button_down, line_level,
    input  ready
  );
  modport sink (
    input  valid, command, move_x, move_y, button_index, button_down, line_level,
    output ready
  );
endinterface

// Result channel out of the engine.
interface smpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       byte_valid;
  logic       clear_to_send;
  logic       last_of_run;

  modport source (
    output valid, tx_byte, byte_valid, clear_to_send, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, tx_byte, byte_valid, clear_to_send, last_of_run,
    output ready
  );
endinterface

@@ rtl/smpe_core.sv @@
`timescale 1ns / 1ps

module smpe_core #(
  parameter int BUTTON_COUNT = smpe_pkg::BtnCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  smpe_in_if.sink         evt_i,
  input  logic            room_i,
  output smpe_pkg::push_t push_o
);
  import smpe_pkg::*;

  // input register
  logic                    valid_q;
  logic [2:0]              cmd_q;
  logic signed [11:0]      mx_q, my_q;
  logic [2:0]              bidx_q;
  logic                    bdown_q, lvl_q;

  // mouse state
  logic                    updating_q, updating_d;
  logic signed [15:0]      accum_x_q, accum_x_d;
  logic signed [15:0]      accum_y_q, accum_y_d;
  logic [BUTTON_COUNT-1:0] btn_q, btn_d;
  logic                    pending_q, pending_d;
  logic                    cts_q, cts_d;

  logic                    fire;
  logic signed [16:0]      sum_x, sum_y;
  logic signed [15:0]      sat_x, sat_y;
  logic [7:0]              px, py;
  push_t                   push;

  assign fire        = valid_q & room_i;
  assign evt_i.ready = ~valid_q | room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      cmd_q   <= evt_i.command;
      mx_q    <= evt_i.move_x;
      my_q    <= evt_i.move_y;
      bidx_q  <= evt_i.button_index;
      bdown_q <= evt_i.button_down;
      lvl_q   <= evt_i.line_level;
    end
  end

  always_comb begin
    sum_x = 17'(accum_x_q) + 17'(mx_q);
    sum_y = 17'(accum_y_q) + 17'(my_q);
    sat_x = sat16(sum_x);
    sat_y = sat16(sum_y);
    px    = clamp8(accum_x_q);
    py    = clamp8(accum_y_q);
  end

  always_comb begin
    updating_d = updating_q;
    accum_x_d  = accum_x_q;
    accum_y_d  = accum_y_q;
    btn_d      = btn_q;
    pending_d  = pending_q;
    cts_d      = cts_q;
    push       = '0;

    unique case (cmd_q)
      CMD_MOTION: begin
        accum_x_d = sat_x;
        accum_y_d = sat_y;
        if (sat_x != '0 || sat_y != '0) begin
          pending_d = 1'b1;
        end
      end
      CMD_BUTTON: begin
        if (int'(bidx_q) < BUTTON_COUNT) begin
          for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (bidx_q == 3'(i)) begin
              btn_d[i] = bdown_q;
            end
          end
          pending_d = 1'b1;
        end
      end
      CMD_DTR: begin
        pending_d = 1'b0;
        push.cnt  = ResCntW'(1);
        push.res[0].last_of_run = 1'b1;
        if (lvl_q) begin
          accum_x_d  = '0;
          accum_y_d  = '0;
          updating_d = 1'b1;
          push.res[0].tx_byte       = IdByte;
          push.res[0].byte_valid    = 1'b1;
          push.res[0].clear_to_send = cts_q;
        end else begin
          updating_d = 1'b0;
          cts_d      = 1'b0;
        end
      end
      CMD_RTS: begin
        cts_d    = lvl_q;
        push.cnt = ResCntW'(1);
        push.res[0].tx_byte       = IdByte;
        push.res[0].byte_valid    = 1'b1;
        push.res[0].clear_to_send = lvl_q;
        push.res[0].last_of_run   = 1'b1;
      end
      CMD_TICK: begin
        if (updating_q && pending_q) begin
          accum_x_d = '0;
          accum_y_d = '0;
          pending_d = 1'b0;
          push.cnt  = ResCntW'(3);
          push.res[0].tx_byte = {SyncBits, btn_q[0], btn_q[1], py[7:6], px[7:6]};
          push.res[1].tx_byte = {DataBits, px[5:0]};
          push.res[2].tx_byte = {DataBits, py[5:0]};
          for (int k = 0; k < 3; k++) begin
            push.res[k].byte_valid    = 1'b1;
            push.res[k].clear_to_send = cts_q;
          end
          push.res[2].last_of_run = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (!fire) begin
      push.cnt = '0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      updating_q <= 1'b0;
      accum_x_q  <= '0;
      accum_y_q  <= '0;
      btn_q      <= '0;
      pending_q  <= 1'b0;
      cts_q      <= 1'b0;
    end else if (fire) begin
      updating_q <= updating_d;
      accum_x_q  <= accum_x_d;
      accum_y_q  <= accum_y_d;
      btn_q      <= btn_d;
      pending_q  <= pending_d;
      cts_q      <= cts_d;
    end
  end

endmodule

@@ rtl/smpe_txq.sv @@
`timescale 1ns / 1ps

module smpe_txq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  smpe_pkg::push_t push_i,
  output logic            room_o,
  smpe_out_if.source      res_o
);
  import smpe_pkg::*;

  localparam int PtrW = $clog2(TxqDepth);
  localparam int CntW = $clog2(TxqDepth + 1);

  res_t            mem_q [TxqDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;
  res_t            head;

  // room for a full packet, judged from the registered count only
  assign room_o = count_q <= CntW'(TxqDepth - ResMax);

  assign pop  = res_o.valid & res_o.ready;
  assign head = mem_q[rd_q];

  assign res_o.valid         = count_q != '0;
  assign res_o.tx_byte       = head.tx_byte;
  assign res_o.byte_valid    = head.byte_valid;
  assign res_o.clear_to_send = head.clear_to_send;
  assign res_o.last_of_run   = head.last_of_run;

  assign count_d = count_q + CntW'(push_i.cnt) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ResMax; k++) begin
      if (ResCntW'(k) < push_i.cnt) begin
        mem_q[wr_q + PtrW'(k)] <= push_i.res[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PtrW'(push_i.cnt);
      rd_q    <= rd_q + PtrW'(pop);
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/serial_mouse_packet_engine.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Role    Payload
// evt_i     in   sink    command, move_x, move_y, button_index, button_down, line_level
// res_o     out  source  tx_byte, byte_valid, clear_to_send, last_of_run
//
// An event is registered on acceptance and handled once the queue has room; its results
// land in a four-entry queue and leave one per cycle while res_o is ready.
// A new event is taken whenever the input register is free or the queue holds at most one
// result; an event of any command waits in the input register until then.
// Reset (rst_ni, async low) clears the mouse state, the input register and the queue.
// A stalled res_o holds its head result; once the queue holds two or more results the
// registered event waits and evt_i.ready drops.

module serial_mouse_packet_engine #(
  parameter int BUTTON_COUNT = smpe_pkg::BtnCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smpe_in_if.sink     evt_i,
  smpe_out_if.source  res_o
);
  import smpe_pkg::*;

  push_t push;
  logic  room;

  // Event decode, mouse state and packet formatting.
  smpe_core #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_i),
    .room_i (room),
    .push_o (push)
  );

  // Result queue: up to three results per event, one out per cycle while res_o is ready.
  smpe_txq u_txq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule

@@ sim/serial_mouse_packet_engine_test.sv @@
`timescale 1ns / 1ps

// Top-level regression for the serial mouse packet engine.
// Events go in on evt, results come back on res. A model of the mouse kept in this
// module predicts the results of every accepted event; the monitor pops one
// expected result per accepted result and compares it field by field.
module serial_mouse_packet_engine_test;
  import smpe_pkg::*;

  localparam int NBtn = BtnCountDef;

  // Command codes the engine must ignore.
  localparam logic [2:0] CmdSpareFirst = 3'd5;
  localparam logic [2:0] CmdSpareLast  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  smpe_in_if  evt ();
  smpe_out_if res ();

  serial_mouse_packet_engine #(
    .BUTTON_COUNT(NBtn)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .res_o (res)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Mouse model: state mirrors the engine after every accepted request.
  // ---------------------------------------------------------------------------
  logic               updating;
  logic               change_pending;
  logic               cts_level;
  logic signed [15:0] accum_x;
  logic signed [15:0] accum_y;
  logic               btn_down [NBtn];

  res_t tx_due [$];   // results still owed by the engine, oldest first
  res_t tx_want;
  int   mismatches = 0;
  bit   idle_on    = 1'b1;  // random gaps on both channels

  function automatic logic signed [15:0] saturate_sum(logic signed [16:0] s);
    if (s > 17'sd32767) begin
      return 16'sh7FFF;
    end else if (s < -17'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  // Accumulator clipped to one signed byte for the packet.
  function automatic logic [7:0] clip_delta(logic signed [15:0] v);
    if (v > 16'sd127) begin
      return 8'h7F;
    end else if (v < -16'sd128) begin
      return 8'h80;
    end
    return v[7:0];
  endfunction

  // Results always carry the CTS level after the request took effect.
  function automatic void owe_byte(logic [7:0] b, logic has_byte, logic last);
    res_t r;
    r.tx_byte       = b;
    r.byte_valid    = has_byte;
    r.clear_to_send = cts_level;
    r.last_of_run   = last;
    tx_due.push_back(r);
  endfunction

  function automatic void mouse_event(logic [2:0] cmd, logic signed [11:0] mx,
                                      logic signed [11:0] my, logic [2:0] bi,
                                      logic bd, logic lvl);
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic [7:0]         px;
    logic [7:0]         py;
    case (cmd)
      CMD_MOTION: begin
        sx = accum_x + mx;
        sy = accum_y + my;
        accum_x = saturate_sum(sx);
        accum_y = saturate_sum(sy);
        if (accum_x != 0 || accum_y != 0) begin
          change_pending = 1'b1;
        end
      end
      CMD_BUTTON: begin
        // out-of-range index: no change at all
        if (bi < NBtn) begin
          btn_down[bi] = bd;
          change_pending = 1'b1;
        end
      end
      CMD_DTR: begin
        change_pending = 1'b0;
        if (lvl) begin
          accum_x  = '0;
          accum_y  = '0;
          updating = 1'b1;
          owe_byte(IdByte, 1'b1, 1'b1);
        end else begin
          // power drop: accumulators survive, CTS falls, no byte
          updating  = 1'b0;
          cts_level = 1'b0;
          owe_byte(8'h00, 1'b0, 1'b1);
        end
      end
      CMD_RTS: begin
        cts_level = lvl;
        owe_byte(IdByte, 1'b1, 1'b1);
      end
      CMD_TICK: begin
        if (updating && change_pending) begin
          px = clip_delta(accum_x);
          py = clip_delta(accum_y);
          owe_byte({SyncBits, btn_down[0], btn_down[1], py[7:6], px[7:6]}, 1'b1, 1'b0);
          owe_byte({DataBits, px[5:0]}, 1'b1, 1'b0);
          owe_byte({DataBits, py[5:0]}, 1'b1, 1'b1);
          accum_x = '0;
          accum_y = '0;
          change_pending = 1'b0;
        end
      end
      default: ;  // spare codes do nothing
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (tx_due.size() == 0) begin
        note_mismatch("result with nothing due", int'(res.tx_byte), 0);
      end else begin
        tx_want = tx_due.pop_front();
        if (res.tx_byte !== tx_want.tx_byte)
          note_mismatch("tx_byte", int'(res.tx_byte), int'(tx_want.tx_byte));
        if (res.byte_valid !== tx_want.byte_valid)
          note_mismatch("byte_valid", int'(res.byte_valid), int'(tx_want.byte_valid));
        if (res.clear_to_send !== tx_want.clear_to_send)
          note_mismatch("clear_to_send", int'(res.clear_to_send),
                        int'(tx_want.clear_to_send));
        if (res.last_of_run !== tx_want.last_of_run)
          note_mismatch("last_of_run", int'(res.last_of_run), int'(tx_want.last_of_run));
      end
    end
  end

  // Receiver: ready drops in random bursts while idle_on is set.
  initial begin : sink_stall
    int hold;
    hold = 0;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && hold == 0 && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 13);
      end
      if (idle_on && hold > 0) begin
        res.ready <= 1'b0;
        hold--;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Every task here starts and ends on a falling edge. valid stays high
  // between back-to-back requests; only a gap or a drain lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [2:0] cmd, input logic signed [11:0] mx,
                            input logic signed [11:0] my, input logic [2:0] bi,
                            input logic bd, input logic lvl);
    logic taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    evt.valid        <= 1'b1;
    evt.command      <= cmd;
    evt.move_x       <= mx;
    evt.move_y       <= my;
    evt.button_index <= bi;
    evt.button_down  <= bd;
    evt.line_level   <= lvl;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = evt.ready;
    end
    mouse_event(cmd, mx, my, bi, bd, lvl);
    @(negedge clk_i);
  endtask

  // Hold off until every owed result is back (also used at the end).
  task automatic wait_until_drained;
    evt.valid <= 1'b0;
    while (tx_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // RTS and DTR handling, identification byte, ticks with nothing to send.
  task automatic test_line_control;
    send_event(CMD_TICK, 12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);      // not updating yet
    send_event(CMD_RTS,  12'sd0, 12'sd0, 3'd0, 1'b0, 1'b1);
    send_event(CMD_RTS,  12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);
    send_event(CMD_RTS,  12'sd0, 12'sd0, 3'd0, 1'b0, 1'b1);
    send_event(CMD_DTR,  12'sd0, 12'sd0, 3'd0, 1'b0, 1'b1);
    send_event(CMD_TICK, 12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);      // nothing pending
    send_event(CMD_MOTION, 12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);    // zero motion
    send_event(CMD_TICK, 12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);
  endtask

  // Button changes, including indexes past the last button.
  task automatic test_buttons;
    send_event(CMD_BUTTON, 12'sd0, 12'sd0, 3'd0, 1'b1, 1'b0);
    send_event(CMD_BUTTON, 12'sd0, 12'sd0, 3'd1, 1'b1, 1'b0);
    send_event(CMD_BUTTON, 12'sd0, 12'sd0, 3'd7, 1'b1, 1'b0);
    send_event(CMD_BUTTON, 12'sd0, 12'sd0, 3'(NBtn), 1'b1, 1'b0);
    send_event(CMD_BUTTON, 12'sd0, 12'sd0, 3'(NBtn - 1), 1'b1, 1'b0);
    send_event(CMD_TICK,   12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);
    send_event(CMD_BUTTON, 12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);
    send_event(CMD_TICK,   12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);
  endtask

  // Field extremes and clipping of the packet deltas.
  task automatic test_motion_clip;
    send_event(CMD_MOTION, 12'sh800, 12'sh7FF, 3'd0, 1'b0, 1'b0);
    send_event(CMD_TICK,   12'sd0,   12'sd0,   3'd0, 1'b0, 1'b0);
    send_event(CMD_MOTION, 12'sh7FF, 12'sh800, 3'd7, 1'b1, 1'b1);
    send_event(CMD_TICK,   12'sd0,   12'sd0,   3'd0, 1'b0, 1'b0);
    send_event(CMD_MOTION, 12'sd3,   -12'sd5,  3'd0, 1'b0, 1'b0);
    send_event(CMD_TICK,   12'sd0,   12'sd0,   3'd0, 1'b0, 1'b0);
  endtask

  // Spare codes, then DTR dropping with motion still held in the accumulators.
  task automatic test_spare_and_drop;
    for (int c = CmdSpareFirst; c <= CmdSpareLast; c++) begin
      send_event(3'(c), 12'sh7FF, 12'sh800, 3'd0, 1'b1, 1'b1);
    end
    send_event(CMD_MOTION, 12'sd40, 12'sd9, 3'd0, 1'b0, 1'b0);
    send_event(CMD_DTR,    12'sd0,  12'sd0, 3'd0, 1'b0, 1'b0);
    send_event(CMD_TICK,   12'sd0,  12'sd0, 3'd0, 1'b0, 1'b0);  // not updating
    send_event(CMD_DTR,    12'sd0,  12'sd0, 3'd0, 1'b0, 1'b1);  // clears the motion
    send_event(CMD_TICK,   12'sd0,  12'sd0, 3'd0, 1'b0, 1'b0);
  endtask

  // Long runs of large same-sign motion drive both accumulators into saturation.
  task automatic test_saturation;
    send_event(CMD_DTR, 12'sd0, 12'sd0, 3'($urandom), 1'($urandom), 1'b1);
    repeat (24) begin
      send_event(CMD_MOTION, 12'($urandom_range(1500, 2047)),
                 12'(0 - $urandom_range(1500, 2048)), 3'($urandom), 1'($urandom),
                 1'($urandom));
    end
    send_event(CMD_TICK, 12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);
    repeat (24) begin
      send_event(CMD_MOTION, 12'(0 - $urandom_range(1500, 2048)),
                 12'($urandom_range(1500, 2047)), 3'($urandom), 1'($urandom),
                 1'($urandom));
    end
    send_event(CMD_TICK, 12'sd0, 12'sd0, 3'd0, 1'b0, 1'b0);
  endtask

  // Mixed traffic. DTR mostly rises so the engine spends most time updating
  // and ticks turn into packets; motion is mostly small so packets vary.
  task automatic test_random_traffic(int count);
    int                 pick;
    logic [2:0]         cmd;
    logic signed [11:0] mx;
    logic signed [11:0] my;
    logic               lvl;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      lvl  = 1'($urandom);
      if (pick < 40) begin
        cmd = CMD_MOTION;
      end else if (pick < 55) begin
        cmd = CMD_BUTTON;
      end else if (pick < 80) begin
        cmd = CMD_TICK;
      end else if (pick < 87) begin
        cmd = CMD_DTR;
        lvl = ($urandom_range(0, 3) != 0);
      end else if (pick < 95) begin
        cmd = CMD_RTS;
      end else begin
        cmd = 3'($urandom_range(CmdSpareFirst, CmdSpareLast));
      end
      if ($urandom_range(0, 4) == 0) begin
        mx = 12'($urandom);
        my = 12'($urandom);
      end else begin
        mx = 12'($urandom_range(0, 127)) - 12'sd64;
        my = 12'($urandom_range(0, 127)) - 12'sd64;
      end
      send_event(cmd, mx, my, 3'($urandom), 1'($urandom), lvl);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    updating       = 1'b0;
    change_pending = 1'b0;
    cts_level      = 1'b0;
    accum_x        = '0;
    accum_y        = '0;
    foreach (btn_down[i]) btn_down[i] = 1'b0;

    evt.valid        = 1'b0;
    evt.command      = CMD_MOTION;
    evt.move_x       = '0;
    evt.move_y       = '0;
    evt.button_index = '0;
    evt.button_down  = 1'b0;
    evt.line_level   = 1'b0;
    rst_ni           = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_line_control();
    test_buttons();
    test_motion_clip();
    test_spare_and_drop();
    wait_until_drained();       // sender holds off until every result is back
    test_saturation();
    test_random_traffic(60);
    wait_until_drained();
    // final stretch at full rate on both sides
    idle_on = 1'b0;
    test_random_traffic(30);

    wait_until_drained();
    repeat (16) @(posedge clk_i);   // catch any stray result
    if (mismatches == 0) begin
      $display("serial_mouse_packet_engine regression: pass");
    end else begin
      $display("serial_mouse_packet_engine regression: fail");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin : watchdog
    #3000000;
    $display("serial_mouse_packet_engine regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/smpe_pkg.sv
rtl/smpe_if.sv
rtl/smpe_core.sv
rtl/smpe_txq.sv
rtl/serial_mouse_packet_engine.sv
sim/serial_mouse_packet_engine_test.sv
